// File: sv/hjc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hjc_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int LOOKAHEAD    = 7;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int USED_W       = 3;

   localparam logic [15:0] JAMO_FIRST    = 16'h3131;
   localparam logic [15:0] JAMO_CONS_END = 16'h314E;
   localparam logic [15:0] VOWEL_FIRST   = 16'h314F;
   localparam logic [15:0] VOWEL_END     = 16'h3163;
   localparam logic [15:0] SYLLABLE_BASE = 16'hAC00;
   localparam logic [4:0]  MEDIAL_COUNT  = 5'd21;
   localparam logic [4:0]  FINAL_COUNT   = 5'd28;

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } hjc_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } hjc_cmd_type;

   typedef struct packed {
      logic pending;
      logic slot_free;
   } hjc_status_type;

   function automatic logic is_cons(input logic [15:0] u);
      return u >= JAMO_FIRST && u <= JAMO_CONS_END;
   endfunction

   function automatic logic is_vowel(input logic [15:0] u);
      logic [15:0] off;
      off = u - VOWEL_FIRST;
      if (u < VOWEL_FIRST || u > VOWEL_END) return 1'b0;
      case (off[4:0])
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
         5'd12, 5'd13, 5'd17, 5'd18, 5'd20: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // initial index per consonant, bit 5 set when it cannot start a syllable
   function automatic logic [5:0] initial_idx(input logic [4:0] k);
      case (k)
         5'd0: return 6'd0;   5'd1: return 6'd1;   5'd3: return 6'd2;
         5'd6: return 6'd3;   5'd7: return 6'd4;   5'd8: return 6'd5;
         5'd16: return 6'd6;  5'd17: return 6'd7;  5'd18: return 6'd8;
         5'd20: return 6'd9;  5'd21: return 6'd10; 5'd22: return 6'd11;
         5'd23: return 6'd12; 5'd24: return 6'd13; 5'd25: return 6'd14;
         5'd26: return 6'd15; 5'd27: return 6'd16; 5'd28: return 6'd17;
         5'd29: return 6'd18;
         default: return 6'd32;
      endcase
   endfunction

   function automatic logic [4:0] final_idx(input logic [4:0] k);
      case (k)
         5'd7, 5'd18, 5'd24: return 5'd0;
         default: begin
            if (k < 5'd7) return k + 5'd1;
            else if (k < 5'd18) return k;
            else if (k < 5'd24) return k - 5'd1;
            else if (k < 5'd30) return k - 5'd2;
            else return 5'd0;
         end
      endcase
   endfunction

   function automatic logic [15:0] fold_initial(input logic [15:0] a, input logic [15:0] b);
      if (a != b) return 16'h0;
      if (a == 16'h3131 || a == 16'h3137 || a == 16'h3142 || a == 16'h3145 ||
          a == 16'h3148) return a + 16'h1;
      return 16'h0;
   endfunction

   function automatic logic [15:0] fold_medial(input logic [15:0] a, input logic [15:0] b);
      if (a == 16'h3157 && b == 16'h314F) return 16'h3158;
      if (a == 16'h3157 && b == 16'h3150) return 16'h3159;
      if (a == 16'h3157 && b == 16'h3163) return 16'h315A;
      if (a == 16'h315C && b == 16'h3153) return 16'h315D;
      if (a == 16'h315C && b == 16'h3154) return 16'h315E;
      if (a == 16'h315C && b == 16'h3163) return 16'h315F;
      if (a == 16'h3161 && b == 16'h3163) return 16'h3162;
      if (a == 16'h314F && b == 16'h3163) return 16'h3150;
      if (a == 16'h3151 && b == 16'h3163) return 16'h3152;
      if (a == 16'h3153 && b == 16'h3163) return 16'h3154;
      if (a == 16'h3155 && b == 16'h3163) return 16'h3156;
      return 16'h0;
   endfunction

   function automatic logic [15:0] fold_final(input logic [15:0] a, input logic [15:0] b);
      if (a == 16'h3131 && b == 16'h3145) return 16'h3133;
      if (a == 16'h3134 && b == 16'h3148) return 16'h3135;
      if (a == 16'h3134 && b == 16'h314E) return 16'h3136;
      if (a == 16'h3139) begin
         if (b == 16'h3131) return 16'h313A;
         if (b == 16'h3141) return 16'h313B;
         if (b == 16'h3142) return 16'h313C;
         if (b == 16'h3145) return 16'h313D;
         if (b == 16'h314C) return 16'h313E;
         if (b == 16'h314D) return 16'h313F;
         if (b == 16'h314E) return 16'h3140;
      end
      if (a == 16'h3142 && b == 16'h3145) return 16'h3144;
      return 16'h0;
   endfunction

endpackage
`default_nettype wire

// File: sv/hjc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hjc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        string_end;
   modport source (output valid, output code_unit, output string_end, input ready);
   modport sink (input valid, input code_unit, input string_end, output ready);
endinterface

interface hjc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_unit;
   logic        out_end;
   modport source (output valid, output out_unit, output out_end, input ready);
   modport sink (input valid, input out_unit, input out_end, output ready);
endinterface
`default_nettype wire

// File: sv/hangul_jamo_composer.sv
// An accepted beat is written into the window, and the check state then registers each result.
// No new unit is taken until the check state has settled its results (at most one
// mid-string, up to 7 at a string end); an output stall holds the check state.
// One decision per cycle, while the output slot is free, from the single decision unit over the window registers.
// Reset (synchronous, active high) empties the window and drops any held result.
`timescale 1ns / 1ps
`default_nettype none
module hangul_jamo_composer (
   input  wire logic clock,
   input  wire logic reset,
   hjc_req_if.sink   req,
   hjc_rsp_if.source rsp
);
   import hjc_pkg::*;

   hjc_cmd_type    cmd;
   hjc_status_type status;

   hjc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hjc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_code_unit  (req.code_unit),
      .req_string_end (req.string_end),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_out_unit   (rsp.out_unit),
      .rsp_out_end    (rsp.out_end)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step)) else $error("load and step together");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready) else $error("ready right after a beat");

   a_no_take_pending: assert property (@(posedge clock) disable iff (reset)
      status.pending |-> !req.ready) else $error("input taken with decisions pending");
endmodule
`default_nettype wire

// File: sv/hjc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hjc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire hjc_pkg::hjc_status_type status,
   output hjc_pkg::hjc_cmd_type       cmd
);
   import hjc_pkg::*;

   hjc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: if (!status.pending) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: cmd.step = status.pending && status.slot_free;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// File: sv/hjc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module hjc_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [15:0]         req_code_unit,
   input  wire logic                req_string_end,
   input  wire hjc_pkg::hjc_cmd_type cmd,
   output hjc_pkg::hjc_status_type  status,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [15:0]              rsp_out_unit,
   output logic                     rsp_out_end
);
   import hjc_pkg::*;

   logic [15:0]       win_ff [WINDOW_DEPTH];
   logic [15:0]       win_in [WINDOW_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              end_ff, end_in;
   logic              valid_ff, valid_in;
   logic [15:0]       unit_ff, unit_in;
   logic              last_ff, last_in;

   // decision signals
   logic [15:0]       c, fi, ini, fm0, med, fm1, wci, wci1, wfs, wfs1, wfs2, ff, unit;
   logic              dbl, cmb, tkf2, tkf1;
   logic [5:0]        cho;
   logic [1:0]        ci, cm;
   logic [USED_W-1:0] fs, used;
   logic [4:0]        jong, j1;
   logic [4:0]        med_off;
   logic [8:0]        mix;
   logic [13:0]       mix28;
   logic [CNT_W-1:0]  n, used_n;

   assign n = count_ff;

   always_comb begin
      c    = win_ff[0];
      fi   = fold_initial(c, win_ff[1]);
      dbl  = n > CNT_W'(2) && is_cons(win_ff[1]) && is_vowel(win_ff[2]) && fi != 16'h0;
      ini  = dbl ? fi : c;
      ci   = dbl ? 2'd2 : 2'd1;
      cho  = initial_idx(5'(ini - JAMO_FIRST));
      wci  = dbl ? win_ff[2] : win_ff[1];
      wci1 = dbl ? win_ff[3] : win_ff[2];
      fm1  = fold_medial(wci, wci1);
      cmb  = CNT_W'(ci) + CNT_W'(1) < n && is_vowel(wci1) && fm1 != 16'h0;
      med  = cmb ? fm1 : wci;
      cm   = cmb ? 2'd2 : 2'd1;
      fs   = USED_W'(ci) + USED_W'(cm);
      case (fs)
         3'd2: begin wfs = win_ff[2]; wfs1 = win_ff[3]; wfs2 = win_ff[4]; end
         3'd3: begin wfs = win_ff[3]; wfs1 = win_ff[4]; wfs2 = win_ff[5]; end
         default: begin wfs = win_ff[4]; wfs1 = win_ff[5]; wfs2 = win_ff[6]; end
      endcase
      ff   = fold_final(wfs, wfs1);
      tkf2 = CNT_W'(fs) < n && is_cons(wfs) &&
             CNT_W'(fs) + CNT_W'(1) < n && is_cons(wfs1) && ff != 16'h0 &&
             (CNT_W'(fs) + CNT_W'(2) >= n || !is_vowel(wfs2));
      j1   = final_idx(5'(wfs - JAMO_FIRST));
      tkf1 = !tkf2 && CNT_W'(fs) < n && is_cons(wfs) &&
             (CNT_W'(fs) + CNT_W'(1) >= n || !is_vowel(wfs1)) && j1 != 5'd0;
      jong = tkf2 ? final_idx(5'(ff - JAMO_FIRST)) : (tkf1 ? j1 : 5'd0);
      med_off = 5'(med - VOWEL_FIRST);
      mix   = 9'(cho[4:0]) * 9'(MEDIAL_COUNT) + 9'(med_off);
      mix28 = 14'(mix) * 14'(FINAL_COUNT);
      fm0  = fold_medial(c, win_ff[1]);

      if (!is_cons(c) && !is_vowel(c)) begin
         unit = c;
         used = 3'd1;
      end else if (is_vowel(c)) begin
         if (n > CNT_W'(1) && is_vowel(win_ff[1]) && fm0 != 16'h0) begin
            unit = fm0;
            used = 3'd2;
         end else begin
            unit = c;
            used = 3'd1;
         end
      end else if (cho[5] || CNT_W'(ci) >= n || !is_vowel(wci)) begin
         unit = ini;
         used = USED_W'(ci);
      end else begin
         unit = SYLLABLE_BASE + 16'(mix28) + 16'(jong);
         used = fs + (tkf2 ? 3'd2 : (tkf1 ? 3'd1 : 3'd0));
      end
      used_n = (CNT_W'(used) > n) ? n : CNT_W'(used);
   end

   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win_in[i] = win_ff[i];
      count_in = count_ff;
      end_in   = end_ff;
      valid_in = valid_ff && !rsp_ready;
      unit_in  = unit_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         end_in = req_string_end;
         if (count_ff < CNT_W'(WINDOW_DEPTH)) begin
            win_in[count_ff[IDX_W-1:0]] = req_code_unit;
            count_in = count_ff + CNT_W'(1);
         end
      end else if (cmd.step) begin
         for (int k = 1; k <= LOOKAHEAD; k++) begin
            if (used_n == CNT_W'(k)) begin
               for (int i = 0; i + k < WINDOW_DEPTH; i++) win_in[i] = win_ff[i + k];
            end
         end
         count_in = count_ff - used_n;
         valid_in = 1'b1;
         unit_in  = unit;
         last_in  = end_ff && count_ff == used_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         end_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         end_ff   <= end_in;
         valid_ff <= valid_in;
      end
      unit_ff <= unit_in;
      last_ff <= last_in;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_ff[i] <= win_in[i];
   end

   assign status.pending   = count_ff != '0 && (end_ff || count_ff >= CNT_W'(LOOKAHEAD));
   assign status.slot_free = !valid_ff || rsp_ready;
   assign rsp_valid    = valid_ff;
   assign rsp_out_unit = unit_ff;
   assign rsp_out_end  = last_ff;
endmodule
`default_nettype wire
